[rtl/rmm_pkg.sv]
// ----------------------------------------------------------------------------
// rmm_pkg - shared types and constants for the ring modulator
// Holds the register map, waveform codes, datapath widths and the
// quarter-wave sine table that is built at elaboration.
// ----------------------------------------------------------------------------
package rmm_pkg;

	// Datapath widths
	localparam int SAMPLE_W = 16;                 // audio sample, Q1.15
	localparam int MOD_W    = 17;                 // modulator, -1.0 .. +1.0 inclusive
	localparam int OP_W     = 18;                 // multiplier operand
	localparam int ACC_W    = 2 * OP_W;           // product / accumulator
	localparam int FRAC_W   = 15;                 // Q15 fraction bits
	localparam int WET_W    = 16;                 // wet_mix register
	localparam int INC_W    = 32;                 // phase_increment register
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Q15 unity as a modulator or mix weight
	localparam int Q15_ONE = 32768;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WAVEFORM  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WET_MIX   = 2'd2;

	// Register reset values
	localparam logic [INC_W-1:0] PHASE_INC_RST = 32'd44739243;
	localparam logic [WET_W-1:0] WET_MIX_RST   = 16'd26214;

	// Modulator shapes
	typedef enum logic [1:0] {
		WAVE_SINE     = 2'd0,
		WAVE_SAW      = 2'd1,
		WAVE_SQUARE   = 2'd2,
		WAVE_TRIANGLE = 2'd3
	} wave_t;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL_XM,
		S_MUL_DRY,
		S_MUL_WET,
		S_FINISH
	} state_t;

	// Control of the shared multiply-accumulate unit
	typedef struct packed {
		logic en;     // update the accumulator this cycle
		logic clear;  // start from zero instead of the held sum
	} mac_ctrl_t;

	// Quarter-wave sine table: TAB_N+1 entries of SINE_W bits
	localparam int TAB_BITS   = 8;
	localparam int TAB_N      = 1 << TAB_BITS;
	localparam int SINE_W     = 15;
	localparam int SINE_ROM_W = (TAB_N + 1) * SINE_W;

	localparam longint Q30_ONE     = 64'sd1073741824;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;

	// Entry k is round(32767*sin(pi*k/(2N))) from a Q30 Taylor series
	function automatic logic [SINE_ROM_W-1:0] build_sine_rom();
		logic [SINE_ROM_W-1:0] rom;
		longint x;
		longint x2;
		longint term;
		longint sum;
		longint v;
		rom = '0;
		for (int k = 0; k <= TAB_N; k++) begin
			x    = longint'(k) * HALF_PI_Q30 / TAB_N;
			x2   = x * x / Q30_ONE;
			term = x;
			sum  = x;
			term = -(term * x2 / Q30_ONE) / 6;   sum = sum + term;
			term = -(term * x2 / Q30_ONE) / 20;  sum = sum + term;
			term = -(term * x2 / Q30_ONE) / 42;  sum = sum + term;
			term = -(term * x2 / Q30_ONE) / 72;  sum = sum + term;
			term = -(term * x2 / Q30_ONE) / 110; sum = sum + term;
			term = -(term * x2 / Q30_ONE) / 156; sum = sum + term;
			term = -(term * x2 / Q30_ONE) / 210; sum = sum + term;
			term = -(term * x2 / Q30_ONE) / 272; sum = sum + term;
			if (sum < 0) begin
				sum = 0;
			end
			v = (sum * 32767 + Q30_ONE / 2) / Q30_ONE;
			if (v > 32767) begin
				v = 32767;
			end
			rom[k*SINE_W +: SINE_W] = v[SINE_W-1:0];
		end
		return rom;
	endfunction

	localparam logic [SINE_ROM_W-1:0] SINE_ROM = build_sine_rom();

endpackage

[rtl/rmm_if.sv]
// ----------------------------------------------------------------------------
// rmm_if - channel interfaces of the ring modulator
// Sample input, result output and configuration write channels, each with
// valid/ready and a source and a sink modport.
// ----------------------------------------------------------------------------
interface rmm_in_if;
	logic                               valid;
	logic                               ready;
	logic signed [rmm_pkg::SAMPLE_W-1:0] sample_in;
	logic                               restart;

	modport source (output valid, output sample_in, output restart, input ready);
	modport sink   (input valid, input sample_in, input restart, output ready);
endinterface

interface rmm_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [rmm_pkg::SAMPLE_W-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink   (input valid, input sample_out, output ready);
endinterface

interface rmm_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [rmm_pkg::CFG_IDX_W-1:0]     index;
	logic [rmm_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/rmm_wavegen.sv]
// ----------------------------------------------------------------------------
// rmm_wavegen - modulator shape generator
// Maps a phase word to a sine, saw, square or triangle value in signed Q15,
// where +32768 stands for exactly +1.
// ----------------------------------------------------------------------------
module rmm_wavegen #(
	parameter int PHASE_BITS = 32
) (
	input  logic [PHASE_BITS-1:0]              phase,
	input  rmm_pkg::wave_t                     waveform,
	output logic signed [rmm_pkg::MOD_W-1:0]   modulator
);
	import rmm_pkg::*;

	localparam logic signed [MOD_W-1:0] MOD_POS_ONE = MOD_W'(Q15_ONE);
	localparam logic signed [MOD_W-1:0] MOD_NEG_ONE = -MOD_W'(Q15_ONE);

	logic [1:0]                quad;
	logic [TAB_BITS-1:0]       idx;
	logic [TAB_BITS:0]         sel;
	logic [SINE_W-1:0]         tab_val;
	logic signed [MOD_W-1:0]   sine_v;
	logic signed [MOD_W-1:0]   saw_v;
	logic [MOD_W-1:0]          saw_abs;
	logic signed [MOD_W:0]     tri_wide;
	logic signed [MOD_W-1:0]   square_v;

	// Sine: fold the quarter-wave table by quadrant
	always_comb begin
		quad    = phase[PHASE_BITS-1 -: 2];
		idx     = phase[PHASE_BITS-3 -: TAB_BITS];
		sel     = quad[0] ? ((TAB_BITS+1)'(TAB_N) - {1'b0, idx}) : {1'b0, idx};
		tab_val = SINE_ROM[sel*SINE_W +: SINE_W];
		sine_v  = quad[1] ? -$signed({2'b00, tab_val}) : $signed({2'b00, tab_val});
	end

	// Saw, triangle and square from the top of the phase
	always_comb begin
		saw_v    = $signed({phase[PHASE_BITS-1], phase[PHASE_BITS-1 -: SAMPLE_W]});
		saw_abs  = saw_v[MOD_W-1] ? MOD_W'(-saw_v) : MOD_W'(saw_v);
		tri_wide = $signed({saw_abs, 1'b0}) - (MOD_W+1)'(Q15_ONE);
		// exactly one half counts as the low half
		square_v = (phase[PHASE_BITS-1] && (|phase[PHASE_BITS-2:0])) ? MOD_POS_ONE
		                                                               : MOD_NEG_ONE;
	end

	// Select the configured shape
	always_comb begin
		unique case (waveform)
			WAVE_SINE:     modulator = sine_v;
			WAVE_SAW:      modulator = saw_v;
			WAVE_SQUARE:   modulator = square_v;
			WAVE_TRIANGLE: modulator = tri_wide[MOD_W-1:0];
			default:       modulator = '0;
		endcase
	end

endmodule

[rtl/rmm_mac.sv]
// ----------------------------------------------------------------------------
// rmm_mac - shared multiply-accumulate unit
// One signed 18x18 multiplier feeding a registered accumulator; the
// sequencer clears or accumulates one product per cycle while ctrl.en is set.
// ----------------------------------------------------------------------------
module rmm_mac (
	input  logic                               clk,
	input  logic                               arst_n,
	input  rmm_pkg::mac_ctrl_t                 ctrl,
	input  logic signed [rmm_pkg::OP_W-1:0]    op_a,
	input  logic signed [rmm_pkg::OP_W-1:0]    op_b,
	output logic signed [rmm_pkg::ACC_W-1:0]   acc
);
	import rmm_pkg::*;

	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] product;
	logic signed [ACC_W-1:0] base;

	// Form the product and the running base
	always_comb begin
		product = op_a * op_b;
		base    = ctrl.clear ? '0 : acc_q;
	end

	// Update the accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.en) begin
			acc_q <= base + product;
		end
	end

	assign acc = acc_q;

endmodule

[rtl/ring_modulator_multiwave.sv]
// ----------------------------------------------------------------------------
// ring_modulator_multiwave - ring modulator with LFO and dry/wet mix
// Multiplies each sample by a sine, saw, square or triangle modulator and
// mixes the result with the dry sample by a Q15 wet fraction.
// ----------------------------------------------------------------------------
//
//  channel     role    payload                    transfer when
//  ----------  ------  -------------------------  --------------------------
//  sample_ch   sink    sample_in[15:0], restart   valid && ready
//  result_ch   source  sample_out[15:0]           valid && ready
//  cfg_ch      sink    index[1:0], data[31:0]     valid && ready (always ready)
//
//  A transferred sample makes three passes through the one shared 18x18
//  multiply-accumulate unit, then a finish step loads the result.
//  sample_ch is ready again the cycle after the result is loaded, so a new
//  sample cannot transfer before the last one is through.
//  A result stalled by result_ch waits in the output register; the finish
//  step holds until that register is free. No clearing pass after reset.
//
module ring_modulator_multiwave #(
	parameter int PHASE_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	rmm_in_if.sink           sample_ch,
	rmm_out_if.source        result_ch,
	rmm_cfg_if.sink          cfg_ch
);
	import rmm_pkg::*;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam int Y_W = ACC_W - FRAC_W;

	// Configuration registers
	logic [INC_W-1:0]  phase_inc_q;
	wave_t             waveform_q;
	logic [WET_W-1:0]  wet_mix_q;

	// Working registers
	state_t                     state_q, state_d;
	logic [PHASE_BITS-1:0]      phase_acc_q;
	logic signed [SAMPLE_W-1:0] x_q;
	logic signed [MOD_W-1:0]    m_q;
	logic signed [MOD_W-1:0]    wet_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_data_q;

	logic                       in_xfer;
	logic                       load_out;
	logic [PHASE_BITS-1:0]      phase_now;
	logic signed [MOD_W-1:0]    mod_now;
	logic [MOD_W-1:0]           w_clamped;
	logic [MOD_W-1:0]           w_dry;
	mac_ctrl_t                  mac_ctrl;
	logic signed [OP_W-1:0]     op_a;
	logic signed [OP_W-1:0]     op_b;
	logic signed [ACC_W-1:0]    acc;
	logic signed [Y_W-1:0]      y_full;
	logic signed [SAMPLE_W-1:0] y_sat;

	// Take configuration writes at any time; unknown indexes are dropped
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_inc_q <= PHASE_INC_RST;
			waveform_q  <= WAVE_SQUARE;
			wet_mix_q   <= WET_MIX_RST;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.index)
				REG_PHASE_INC: phase_inc_q <= cfg_ch.data;
				REG_WAVEFORM:  waveform_q  <= wave_t'(cfg_ch.data[1:0]);
				REG_WET_MIX:   wet_mix_q   <= cfg_ch.data[WET_W-1:0];
				default:       ;
			endcase
		end
	end

	// Phase of this sample: zero on restart
	assign in_xfer   = sample_ch.valid && sample_ch.ready;
	assign phase_now = sample_ch.restart ? '0 : phase_acc_q;

	rmm_wavegen #(
		.PHASE_BITS (PHASE_BITS)
	) u_wavegen (
		.phase     (phase_now),
		.waveform  (waveform_q),
		.modulator (mod_now)
	);

	// Capture the sample and modulator, advance the phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc_q <= '0;
		end else if (in_xfer) begin
			phase_acc_q <= phase_now + PHASE_BITS'(phase_inc_q);
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			x_q <= sample_ch.sample_in;
			m_q <= mod_now;
		end
		if (state_q == S_MUL_DRY) begin
			wet_q <= acc[FRAC_W +: MOD_W];
		end
	end

	// Wet weight, limited to one, and its dry complement
	always_comb begin
		w_clamped = (wet_mix_q > WET_W'(Q15_ONE)) ? MOD_W'(Q15_ONE) : {1'b0, wet_mix_q};
		w_dry     = MOD_W'(Q15_ONE) - w_clamped;
	end

	// Sequencer: next state, unit control and operand select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		sample_ch.ready  = 1'b0;
		load_out         = 1'b0;
		mac_ctrl         = '0;
		op_a             = '0;
		op_b             = '0;
		unique case (state_q)
			S_IDLE: begin
				sample_ch.ready = 1'b1;
				if (sample_ch.valid) begin
					state_d = S_MUL_XM;
				end
			end
			S_MUL_XM: begin
				mac_ctrl = '{en: 1'b1, clear: 1'b1};
				op_a     = OP_W'(x_q);
				op_b     = OP_W'(m_q);
				state_d  = S_MUL_DRY;
			end
			S_MUL_DRY: begin
				mac_ctrl = '{en: 1'b1, clear: 1'b1};
				op_a     = $signed({1'b0, w_dry});
				op_b     = OP_W'(x_q);
				state_d  = S_MUL_WET;
			end
			S_MUL_WET: begin
				mac_ctrl = '{en: 1'b1, clear: 1'b0};
				op_a     = $signed({1'b0, w_clamped});
				op_b     = OP_W'(wet_q);
				state_d  = S_FINISH;
			end
			S_FINISH: begin
				if (!out_valid_q || result_ch.ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	rmm_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.op_a   (op_a),
		.op_b   (op_b),
		.acc    (acc)
	);

	// Drop the fraction and saturate to the sample range
	always_comb begin
		y_full = acc[ACC_W-1:FRAC_W];
		if (y_full > Y_W'(SAMPLE_MAX)) begin
			y_sat = SAMPLE_MAX;
		end else if (y_full < Y_W'(SAMPLE_MIN)) begin
			y_sat = SAMPLE_MIN;
		end else begin
			y_sat = y_full[SAMPLE_W-1:0];
		end
	end

	// Output register: hold the result until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= y_sat;
		end
	end

	assign result_ch.valid      = out_valid_q;
	assign result_ch.sample_out = out_data_q;

endmodule

[rtl/rmm_checker.sv]
// ----------------------------------------------------------------------------
// rmm_checker - port-level checks for the ring modulator
// Watches the channels of the top level over time and is bound to it.
// ----------------------------------------------------------------------------
module rmm_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic signed [rmm_pkg::SAMPLE_W-1:0] out_sample,
	input logic                               cfg_ready
);
	import rmm_pkg::*;

	// Busy for the whole multiply sequence after a sample transfer
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready)
		else $error("sample channel ready during the multiply sequence");

	// Configuration writes are never stalled
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration channel not ready");

	// A stalled result stays valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped before its transfer");

	// A stalled result keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(out_sample))
		else $error("stalled result changed");

endmodule

bind ring_modulator_multiwave rmm_checker u_rmm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (sample_ch.valid),
	.in_ready   (sample_ch.ready),
	.out_valid  (result_ch.valid),
	.out_ready  (result_ch.ready),
	.out_sample (result_ch.sample_out),
	.cfg_ready  (cfg_ch.ready)
);
